>>> src/erm_pkg.sv
`default_nettype none
package erm_pkg;

  localparam int AngleBits  = 16;
  localparam int FracBits   = 14;
  localparam int TrigStages = 16;
  localparam int WorkBits   = FracBits + 8;
  localparam int CordicW    = WorkBits + 3;
  localparam int ValW       = FracBits + 2;
  localparam int ProdW      = 2 * ValW;
  localparam int SumW       = ValW + 1;
  localparam int OutW       = 16;

  localparam logic [31:0] CordicKQ30 = 32'd652032874;

  typedef logic signed [CordicW-1:0] cw_t;
  typedef logic signed [32:0]        zw_t;
  typedef logic signed [ValW-1:0]    val_t;
  typedef logic [1:0]                quad_t;

  typedef struct packed {
    logic [AngleBits-1:0] angle_x;
    logic [AngleBits-1:0] angle_y;
    logic [AngleBits-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [OutW-1:0] right_x;
    logic signed [OutW-1:0] right_y;
    logic signed [OutW-1:0] right_z;
    logic signed [OutW-1:0] up_x;
    logic signed [OutW-1:0] up_y;
    logic signed [OutW-1:0] up_z;
    logic signed [OutW-1:0] fwd_x;
    logic signed [OutW-1:0] fwd_y;
    logic signed [OutW-1:0] fwd_z;
  } matrix_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic cw_t cordic_x0();
    logic [32:0] r;
    r = {1'b0, CordicKQ30} + (33'd1 << (30 - WorkBits - 1));
    return cw_t'(r >> (30 - WorkBits));
  endfunction

  // round product by FracBits, arithmetic
  function automatic val_t mul_rnd(input val_t a, input val_t b);
    logic signed [ProdW-1:0] p;
    p = a * b;
    p = p + (ProdW'(1) <<< (FracBits - 1));
    return val_t'(p >>> FracBits);
  endfunction

  function automatic logic signed [OutW-1:0] pack(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] one;
    one = SumW'(1) <<< FracBits;
    if (v > one)       return OutW'(one);
    else if (v < -one) return OutW'(-one);
    else               return OutW'(v);
  endfunction

endpackage
`default_nettype wire

>>> src/erm_if.sv
`default_nettype none
interface erm_in_if import erm_pkg::*;;
  logic    valid;
  logic    ready;
  angles_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface erm_out_if import erm_pkg::*;;
  logic    valid;
  logic    ready;
  matrix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/erm_cordic.sv
`default_nettype none
module erm_cordic import erm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [AngleBits-1:0] angle_i,
  output      val_t                 sin_o,
  output      val_t                 cos_o
);

  localparam int N = (TrigStages < 24) ? TrigStages : 24;

  cw_t   x_q [N+1];
  cw_t   y_q [N+1];
  zw_t   z_q [N+1];
  quad_t q_q [N+1];
  val_t  sin_q, cos_q;

  logic [31:0] a32;
  quad_t       q0;
  logic [31:0] d0;

  assign a32 = 32'(angle_i) << (32 - AngleBits);
  assign q0  = quad_t'((a32 + 32'h2000_0000) >> 30);
  assign d0  = a32 - ({30'd0, q0} << 30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= cordic_x0();
      y_q[0] <= '0;
      z_q[0] <= zw_t'(signed'(d0));
      q_q[0] <= q0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1] <= q_q[i];
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - zw_t'({1'b0, atan_turn(i)});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + zw_t'({1'b0, atan_turn(i)});
        end
      end
    end
  end

  function automatic val_t fin(input cw_t v);
    cw_t r;
    cw_t one;
    r   = (v + cw_t'(128)) >>> 8;
    one = cw_t'(1) <<< FracBits;
    if (r > one)       return val_t'(one);
    else if (r < -one) return val_t'(-one);
    else               return val_t'(r);
  endfunction

  val_t sv, cv;
  assign sv = fin(y_q[N]);
  assign cv = fin(x_q[N]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (q_q[N])
        2'd0: begin sin_q <= sv;  cos_q <= cv;  end
        2'd1: begin sin_q <= cv;  cos_q <= -sv; end
        2'd2: begin sin_q <= -sv; cos_q <= -cv; end
        default: begin sin_q <= -cv; cos_q <= sv; end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

>>> src/euler_rotation_matrix.sv
// Euler angle (Z, X, Y order) to 3x3 rotation matrix. Takes one item per cycle
// while ready is high. Each item passes in order through an input register,
// three pipelined CORDIC units of one stage per iteration, a quadrant fix
// stage, then two registered multiply stages and a sum/saturate stage. The
// whole pipeline advances when the output register is empty or taken, so ready
// falls only while a result is held back.
`default_nettype none
module euler_rotation_matrix import erm_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  erm_in_if.sink   in_i,
  erm_out_if.source out_o
);

  localparam int N    = (TrigStages < 24) ? TrigStages : 24;
  localparam int Lat  = N + 4;

  logic           en;
  logic [Lat-1:0] v_q;
  logic           out_v_q;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[Lat-2:0], in_i.valid};
      out_v_q <= v_q[Lat-1];
    end
  end

  val_t sx, cx, sy, cy, sz, cz;

  erm_cordic u_cx (.clk_i, .en_i(en), .angle_i(in_i.data.angle_x), .sin_o(sx), .cos_o(cx));
  erm_cordic u_cy (.clk_i, .en_i(en), .angle_i(in_i.data.angle_y), .sin_o(sy), .cos_o(cy));
  erm_cordic u_cz (.clk_i, .en_i(en), .angle_i(in_i.data.angle_z), .sin_o(sz), .cos_o(cz));

  // first products
  val_t szsx_q, czsx_q, czcy_q, szcy_q, cxsy_q, szcx_q, czcx_q, czsy_q, szsy_q, cxcy_q;
  val_t sx1_q, sy1_q, cy1_q;
  // second products
  val_t p_szsxsy_q, p_czsxsy_q, p_szsxcy_q, p_czsxcy_q;
  val_t czcy2_q, szcy2_q, cxsy2_q, szcx2_q, czcx2_q, czsy2_q, szsy2_q, cxcy2_q, sx2_q;
  matrix_t m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      szsx_q <= mul_rnd(sz, sx);
      czsx_q <= mul_rnd(cz, sx);
      czcy_q <= mul_rnd(cz, cy);
      szcy_q <= mul_rnd(sz, cy);
      cxsy_q <= mul_rnd(cx, sy);
      szcx_q <= mul_rnd(sz, cx);
      czcx_q <= mul_rnd(cz, cx);
      czsy_q <= mul_rnd(cz, sy);
      szsy_q <= mul_rnd(sz, sy);
      cxcy_q <= mul_rnd(cx, cy);
      sx1_q  <= sx;
      sy1_q  <= sy;
      cy1_q  <= cy;

      p_szsxsy_q <= mul_rnd(szsx_q, sy1_q);
      p_czsxsy_q <= mul_rnd(czsx_q, sy1_q);
      p_szsxcy_q <= mul_rnd(szsx_q, cy1_q);
      p_czsxcy_q <= mul_rnd(czsx_q, cy1_q);
      czcy2_q <= czcy_q;  szcy2_q <= szcy_q;  cxsy2_q <= cxsy_q;
      szcx2_q <= szcx_q;  czcx2_q <= czcx_q;  czsy2_q <= czsy_q;
      szsy2_q <= szsy_q;  cxcy2_q <= cxcy_q;  sx2_q   <= sx1_q;

      m_q.right_x <= pack(SumW'(czcy2_q) - SumW'(p_szsxsy_q));
      m_q.right_y <= pack(SumW'(p_czsxsy_q) + SumW'(szcy2_q));
      m_q.right_z <= pack(-SumW'(cxsy2_q));
      m_q.up_x    <= pack(-SumW'(szcx2_q));
      m_q.up_y    <= pack(SumW'(czcx2_q));
      m_q.up_z    <= pack(SumW'(sx2_q));
      m_q.fwd_x   <= pack(SumW'(p_szsxcy_q) + SumW'(czsy2_q));
      m_q.fwd_y   <= pack(SumW'(szsy2_q) - SumW'(p_czsxcy_q));
      m_q.fwd_z   <= pack(SumW'(cxcy2_q));
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = m_q;

endmodule
`default_nettype wire

>>> src/erm_checker.sv
`default_nettype none
module erm_checker import erm_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_ready_i,
  input wire logic    out_valid_i,
  input wire logic    out_ready_i,
  input wire matrix_t out_data_i
);

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i) else $error("input stalled with free output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled item changed");

  a_up_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.up_z <= 16'sd16384 && out_data_i.up_z >= -16'sd16384))
    else $error("element out of range");

  a_fwd_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.fwd_z <= 16'sd16384 && out_data_i.fwd_z >= -16'sd16384))
    else $error("element out of range");

endmodule

bind euler_rotation_matrix erm_checker u_erm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire
